>>> design/flacfbf_pkg.sv
// ----------------------------------------------------------------------------
// flacfbf_pkg
// Status codes, CRC-16 step and header helpers for the FLAC frame boundary
// finder.
// ----------------------------------------------------------------------------
package flacfbf_pkg;

	typedef enum logic [1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NO_SYNC   = 2'd1,
		STATUS_SHORT     = 2'd2,
		STATUS_NO_BOUND  = 2'd3
	} status_t;

	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
	localparam logic [7:0]  SYNC2_MASK   = 8'hFC;
	localparam logic [7:0]  SYNC2_VALUE  = 8'hF8;
	localparam logic [23:0] DEFAULT_CAP  = 24'd8192;
	localparam int          CFG_W        = 24;
	localparam int          LIMIT_W      = 25;
	localparam int          LEN_W        = 17;

	function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
			else r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [3:0] number_length(logic [7:0] u);
		logic [3:0] n;
		if (u[7] == 1'b0) n = 4'd1;
		else if ((u & 8'hE0) == 8'hC0) n = 4'd2;
		else if ((u & 8'hF0) == 8'hE0) n = 4'd3;
		else if ((u & 8'hF8) == 8'hF0) n = 4'd4;
		else if ((u & 8'hFC) == 8'hF8) n = 4'd5;
		else if ((u & 8'hFE) == 8'hFC) n = 4'd6;
		else n = 4'd7;
		return n;
	endfunction

	function automatic logic [3:0] base_header(logic [7:0] b);
		logic [3:0] h;
		h = 4'd4;
		if (b[7:4] == 4'h6) h = h + 4'd1;
		else if (b[7:4] == 4'h7) h = h + 4'd2;
		if (b[3:0] == 4'hC) h = h + 4'd1;
		else if (b[3:0] == 4'hD || b[3:0] == 4'hE) h = h + 4'd2;
		return h;
	endfunction

	function automatic logic is_sync(logic [7:0] b0, logic [7:0] b1);
		return (b0 == SYNC_BYTE) && ((b1 & SYNC2_MASK) == SYNC2_VALUE);
	endfunction

endpackage

>>> design/flac_frame_boundary_finder.sv
// ----------------------------------------------------------------------------
// flac_frame_boundary_finder
// Scans one window of bytes from a candidate FLAC frame start and reports
// where the frame most likely ends.
// ----------------------------------------------------------------------------
// Input channel: one byte per transaction (data_byte, last_byte) on
// in_valid / in_stall. Output channel: one transaction (status,
// frame_length) per window on out_valid / out_stall, presented in the cycle
// after the byte marked last_byte is taken.
// One byte per cycle, except when in_stall holds a last byte. The bytewise
// CRC-16 step, the match compare and the boundary choice all sit between the
// window state registers and the result register.
// in_stall rises only for a last byte while an earlier result is still
// held by a stalled receiver; other bytes keep flowing under the held
// result. Bytes past WINDOW_BYTES are dropped, a last_byte mark on them
// still closes the window.
// max_frame_size is loaded through cfg_write / cfg_data only while idle, by
// the user; the block does not enforce it. Reset (arst_n low) clears the
// window state, out_valid and max_frame_size; the block then takes bytes.
// ----------------------------------------------------------------------------
module flac_frame_boundary_finder #(
	parameter int WINDOW_BYTES = 98304
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [flacfbf_pkg::CFG_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [flacfbf_pkg::LEN_W-1:0] frame_length
);
	import flacfbf_pkg::*;

	localparam int POS_W = $clog2(WINDOW_BYTES + 1);

	logic [CFG_W-1:0]   max_frame_q;
	logic [15:0]        crc_q, crc_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [7:0]         rb0_q, rb1_q, rb2_q, rb0_n, rb1_n, rb2_n;
	logic [3:0]         hdr_q, hdr_n;
	logic               sync_q, sync_n;
	logic [3:0]         pend_q, pend_n;
	logic               prev_v_q, prev_v_n, run_v_q, run_v_n, syn_v_q, syn_v_n;
	logic [POS_W-1:0]   prev_q, prev_n, run_q, run_n, syn_q, syn_n;
	logic [LIMIT_W-1:0] limit;
	logic [POS_W-1:0]   match_pos;
	logic [15:0]        crc_step;
	status_t            res_status;
	logic [POS_W-1:0]   res_len;
	logic               in_take, out_valid_q;
	status_t            status_q;
	logic [LEN_W-1:0]   len_q;

	assign in_stall = last_byte & out_valid_q & out_stall;
	assign in_take  = in_valid & ~in_stall;
	assign limit    = LIMIT_W'((max_frame_q == '0) ? DEFAULT_CAP : max_frame_q) + LIMIT_W'(2);
	assign match_pos = pos_q + POS_W'(1);
	assign crc_step  = crc16_byte(crc_q, rb1_q);

	always_comb begin
		crc_n    = crc_q;
		pos_n    = pos_q;
		rb0_n    = rb0_q;
		rb1_n    = rb1_q;
		rb2_n    = rb2_q;
		hdr_n    = hdr_q;
		sync_n   = sync_q;
		pend_n   = pend_q;
		prev_v_n = prev_v_q;
		prev_n   = prev_q;
		run_v_n  = run_v_q;
		run_n    = run_q;
		syn_v_n  = syn_v_q;
		syn_n    = syn_q;
		if (pos_q < POS_W'(WINDOW_BYTES)) begin
			if (pos_q == POS_W'(1)) sync_n = is_sync(rb0_q, data_byte);
			if (pos_q == POS_W'(2)) hdr_n = base_header(data_byte);
			if (pos_q == POS_W'(4)) hdr_n = hdr_q + number_length(data_byte);
			if (pos_q >= POS_W'(3) && pend_q[0] && is_sync(rb2_q, rb1_q)) begin
				syn_n   = pos_q - POS_W'(3);
				syn_v_n = 1'b1;
			end
			pend_n = {1'b0, pend_q[3:1]};
			if (pos_q >= POS_W'(2)) begin
				crc_n = crc_step;
				if ((pos_q - POS_W'(1)) >= POS_W'(hdr_n) && crc_step == {rb0_q, data_byte}
						&& LIMIT_W'(match_pos) <= limit) begin
					if (prev_v_q && {1'b0, match_pos} == {1'b0, prev_q} + (POS_W+1)'(1)) begin
						if (!run_v_q) begin
							run_n   = prev_q;
							run_v_n = 1'b1;
						end
					end else begin
						run_v_n = 1'b0;
					end
					prev_n    = match_pos;
					prev_v_n  = 1'b1;
					pend_n[3] = 1'b1;
				end
			end
			rb2_n = rb1_q;
			rb1_n = rb0_q;
			rb0_n = data_byte;
			pos_n = match_pos;
		end
	end

	always_comb begin
		res_status = STATUS_NO_BOUND;
		res_len    = '0;
		if (pos_n < POS_W'(4) || !sync_n) begin
			res_status = STATUS_NO_SYNC;
		end else if (pos_n < POS_W'(5) || pos_n < POS_W'({1'b0, hdr_n} + 5'd8)) begin
			res_status = STATUS_SHORT;
		end else if (syn_v_n) begin
			res_status = STATUS_FOUND;
			res_len    = syn_n;
		end else if (run_v_n) begin
			res_status = STATUS_FOUND;
			res_len    = run_n;
		end else if (prev_v_n) begin
			res_status = STATUS_FOUND;
			res_len    = prev_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= '0;
		end else if (cfg_write) begin
			max_frame_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			pos_q    <= '0;
			rb0_q    <= '0;
			rb1_q    <= '0;
			rb2_q    <= '0;
			hdr_q    <= '0;
			sync_q   <= 1'b0;
			pend_q   <= '0;
			prev_v_q <= 1'b0;
			run_v_q  <= 1'b0;
			syn_v_q  <= 1'b0;
			prev_q   <= '0;
			run_q    <= '0;
			syn_q    <= '0;
		end else if (in_take) begin
			if (last_byte) begin
				crc_q    <= '0;
				pos_q    <= '0;
				rb0_q    <= '0;
				rb1_q    <= '0;
				rb2_q    <= '0;
				hdr_q    <= '0;
				sync_q   <= 1'b0;
				pend_q   <= '0;
				prev_v_q <= 1'b0;
				run_v_q  <= 1'b0;
				syn_v_q  <= 1'b0;
				prev_q   <= '0;
				run_q    <= '0;
				syn_q    <= '0;
			end else begin
				crc_q    <= crc_n;
				pos_q    <= pos_n;
				rb0_q    <= rb0_n;
				rb1_q    <= rb1_n;
				rb2_q    <= rb2_n;
				hdr_q    <= hdr_n;
				sync_q   <= sync_n;
				pend_q   <= pend_n;
				prev_v_q <= prev_v_n;
				run_v_q  <= run_v_n;
				syn_v_q  <= syn_v_n;
				prev_q   <= prev_n;
				run_q    <= run_n;
				syn_q    <= syn_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && last_byte) begin
			status_q <= res_status;
			len_q    <= LEN_W'(res_len);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_length = len_q;

endmodule

>>> design/flacfbf_checker.sv
// ----------------------------------------------------------------------------
// flacfbf_checker
// Port-level checks for the FLAC frame boundary finder, bound to the top.
// ----------------------------------------------------------------------------
module flacfbf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_byte,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    status,
	input logic [flacfbf_pkg::LEN_W-1:0] frame_length
);
	import flacfbf_pkg::*;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_length))
		else $error("result changed while stalled");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> out_valid)
		else $error("last byte without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_byte && !out_valid |=> !out_valid)
		else $error("result without last byte");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && in_valid && last_byte |-> in_stall)
		else $error("last byte taken over held result");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_FOUND |-> frame_length == '0)
		else $error("length set without boundary");

endmodule

bind flac_frame_boundary_finder flacfbf_checker u_flacfbf_checker (.*);
